[rtl/core/imu_cal_pkg.sv]
// Shared types, constants and pipeline stage map for the IMU calibration core.
package imu_cal_pkg;

    localparam int unsigned AXES           = 3;
    localparam int unsigned SAMPLE_W       = 16;
    localparam int unsigned REG_W          = 48;
    localparam int unsigned NUM_REGS       = 5;
    localparam int unsigned REG_IDX_W      = 3;
    localparam int unsigned IMU_WINDOW_LEN = 5;

    // Pipeline stage map, one register stage each.
    localparam int unsigned ST_DIFF    = 0;
    localparam int unsigned ST_PROD    = 1;
    localparam int unsigned ST_CAL     = 2;
    localparam int unsigned ST_SUM     = 3;
    localparam int unsigned ST_MAG     = 4;
    localparam int unsigned ST_RECIP   = 5;
    localparam int unsigned ST_QUO     = 6;
    localparam int unsigned ST_AVG     = 7;
    localparam int unsigned ST_OUT     = 8;
    localparam int unsigned NUM_STAGES = 9;

    localparam logic [REG_W-1:0]           GAIN_ONE_PACKED = 48'h1000_1000_1000;
    localparam logic signed [SAMPLE_W-1:0] GAIN_ONE        = 16'sh1000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ACCEL_OFFSETS   = 3'd0,
        REG_ACCEL_GAINS     = 3'd1,
        REG_GYRO_OFFSETS    = 3'd2,
        REG_COMPASS_OFFSETS = 3'd3,
        REG_COMPASS_GAINS   = 3'd4
    } imu_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t accel_raw_x;
        sample_t accel_raw_y;
        sample_t accel_raw_z;
        sample_t gyro_raw_x;
        sample_t gyro_raw_y;
        sample_t gyro_raw_z;
        sample_t compass_raw_x;
        sample_t compass_raw_y;
        sample_t compass_raw_z;
    } imu_in_t;

    typedef struct packed {
        sample_t avg_accel_x;
        sample_t avg_accel_y;
        sample_t avg_accel_z;
        sample_t cal_accel_x;
        sample_t cal_accel_y;
        sample_t cal_accel_z;
        sample_t gyro_x;
        sample_t gyro_y;
        sample_t gyro_z;
        sample_t compass_x;
        sample_t compass_y;
        sample_t compass_z;
    } imu_out_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [REG_W-1:0]     wdata;
    } imu_cfg_t;

    // Per-stage load strobes: ld[k] loads stage k from stage k-1 (or the input).
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } imu_pipe_ctrl_t;

endpackage

[rtl/core/imu_cal_stream_if.sv]
// Valid/ready stream interface with a typed payload.
interface imu_cal_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/imu_calibrate_and_average_core.sv]
// Top level: nine-axis IMU calibration with accelerometer moving average.
//
//   channel | dir | payload                         | transfer when
//   --------+-----+---------------------------------+----------------------------
//   sample  | in  | imu_in_t, nine raw axes         | sample.valid && sample.ready
//   result  | out | imu_out_t, twelve output axes   | result.valid && result.ready
//   cfg     | in  | imu_cfg_t, register index+data  | cfg.valid (ready tied high)
//
// One sample transfer per cycle sustained while result is taken; each sample passes
// through the stage chain: offset, multiply, round/saturate, window sum, magnitude,
// reciprocal multiply, remainder, correction, output register.
// rst_n asynchronously resets config registers (zero offsets, unity gains) and
// clears ring store, sums, ring slot and stage valids.
// Stalls on result let bubbles in earlier stages fill; sample.ready drops only when
// all nine stages hold a sample and the result is not taken.
module imu_calibrate_and_average_core #(
    parameter int unsigned WINDOW_LEN = imu_cal_pkg::IMU_WINDOW_LEN
) (
    input logic              clk,
    input logic              rst_n,
    imu_cal_stream_if.sink   sample,
    imu_cal_stream_if.source result,
    imu_cal_stream_if.sink   cfg
);
    import imu_cal_pkg::*;

    // Configuration registers, indexed by imu_reg_t.
    logic [REG_W-1:0] regs_reg [NUM_REGS];

    // Stage occupancy and the free/load chain.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   free;
    imu_pipe_ctrl_t        ctrl;

    sample_t accel_raw   [AXES];
    sample_t gyro_raw    [AXES];
    sample_t compass_raw [AXES];
    sample_t accel_cal   [AXES];
    sample_t gyro_cal    [AXES];
    sample_t compass_cal [AXES];
    sample_t accel_avg   [AXES];

    imu_out_t merged;

    // Config port never back-pressures; user sends writes only while idle (block does not enforce it).
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_ACCEL_OFFSETS]   <= '0;
            regs_reg[REG_ACCEL_GAINS]     <= GAIN_ONE_PACKED;
            regs_reg[REG_GYRO_OFFSETS]    <= '0;
            regs_reg[REG_COMPASS_OFFSETS] <= '0;
            regs_reg[REG_COMPASS_GAINS]   <= GAIN_ONE_PACKED;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_ACCEL_OFFSETS:   regs_reg[REG_ACCEL_OFFSETS]   <= cfg.data.wdata;
                REG_ACCEL_GAINS:     regs_reg[REG_ACCEL_GAINS]     <= cfg.data.wdata;
                REG_GYRO_OFFSETS:    regs_reg[REG_GYRO_OFFSETS]    <= cfg.data.wdata;
                REG_COMPASS_OFFSETS: regs_reg[REG_COMPASS_OFFSETS] <= cfg.data.wdata;
                REG_COMPASS_GAINS:   regs_reg[REG_COMPASS_GAINS]   <= cfg.data.wdata;
                default:             ; // unmapped index: dropped
            endcase
        end
    end

    // A stage is free when empty or when its occupant moves on this cycle.
    // A stage can advance into an empty stage ahead of it while later stages hold, so bubbles close up.
    always_comb
    begin
        free[NUM_STAGES] = result.ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            free[k] = !valid_reg[k] || free[k+1];
        end
        ctrl.ld[0] = sample.valid && free[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            ctrl.ld[k] = valid_reg[k-1] && free[k];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ctrl.ld[k] || (valid_reg[k] && !free[k+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample.ready = free[0];
    assign result.valid = valid_reg[NUM_STAGES-1];
    assign result.data  = merged;

    assign accel_raw[0]   = sample.data.accel_raw_x;
    assign accel_raw[1]   = sample.data.accel_raw_y;
    assign accel_raw[2]   = sample.data.accel_raw_z;
    assign gyro_raw[0]    = sample.data.gyro_raw_x;
    assign gyro_raw[1]    = sample.data.gyro_raw_y;
    assign gyro_raw[2]    = sample.data.gyro_raw_z;
    assign compass_raw[0] = sample.data.compass_raw_x;
    assign compass_raw[1] = sample.data.compass_raw_y;
    assign compass_raw[2] = sample.data.compass_raw_z;

    // Nine calibration lanes in parallel; gyro lanes run at unity gain,
    // which reduces to a saturated offset subtract.
    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        imu_cal_axis u_accel (
            .clk  (clk),
            .ctrl (ctrl),
            .raw  (accel_raw[a]),
            .off  (regs_reg[REG_ACCEL_OFFSETS][SAMPLE_W*a +: SAMPLE_W]),
            .gain (regs_reg[REG_ACCEL_GAINS][SAMPLE_W*a +: SAMPLE_W]),
            .cal  (accel_cal[a])
        );

        imu_cal_axis u_gyro (
            .clk  (clk),
            .ctrl (ctrl),
            .raw  (gyro_raw[a]),
            .off  (regs_reg[REG_GYRO_OFFSETS][SAMPLE_W*a +: SAMPLE_W]),
            .gain (GAIN_ONE),
            .cal  (gyro_cal[a])
        );

        imu_cal_axis u_compass (
            .clk  (clk),
            .ctrl (ctrl),
            .raw  (compass_raw[a]),
            .off  (regs_reg[REG_COMPASS_OFFSETS][SAMPLE_W*a +: SAMPLE_W]),
            .gain (regs_reg[REG_COMPASS_GAINS][SAMPLE_W*a +: SAMPLE_W]),
            .cal  (compass_cal[a])
        );

        // Window update happens once per sample, as it enters the sum stage.
        imu_cal_avg #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_avg (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .cal_in (accel_cal[a]),
            .avg    (accel_avg[a])
        );
    end

    imu_cal_merge u_merge (
        .clk         (clk),
        .ctrl        (ctrl),
        .accel_cal   (accel_cal),
        .gyro_cal    (gyro_cal),
        .compass_cal (compass_cal),
        .accel_avg   (accel_avg),
        .result      (merged)
    );

endmodule

[rtl/core/imu_cal_axis.sv]
// One calibration lane: offset subtract, Q4.12 gain, truncate toward zero, saturate.
module imu_cal_axis (
    input  logic                       clk,
    input  imu_cal_pkg::imu_pipe_ctrl_t ctrl,
    input  imu_cal_pkg::sample_t       raw,
    input  imu_cal_pkg::sample_t       off,
    input  imu_cal_pkg::sample_t       gain,
    output imu_cal_pkg::sample_t       cal
);
    import imu_cal_pkg::*;

    localparam int unsigned DIFF_W = SAMPLE_W + 1;
    localparam int unsigned PROD_W = DIFF_W + SAMPLE_W;
    localparam int unsigned FRAC_W = 12;
    localparam int unsigned QUO_W  = PROD_W - FRAC_W;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    sample_t                  cal_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [QUO_W-1:0]  quo;
    sample_t                  cal_next;

    // Bias negatives by 2^12-1 so the arithmetic shift rounds toward zero.
    always_comb
    begin
        biased = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : '0);
        quo    = biased[PROD_W-1:FRAC_W];
        if (quo > QUO_W'(32767))
        begin
            cal_next = 16'sh7fff;
        end
        else if (quo < -QUO_W'(32768))
        begin
            cal_next = 16'sh8000;
        end
        else
        begin
            cal_next = quo[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[ST_DIFF])
        begin
            diff_reg <= DIFF_W'(raw) - DIFF_W'(off);
        end
        if (ctrl.ld[ST_PROD])
        begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(gain);
        end
        if (ctrl.ld[ST_CAL])
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

[rtl/core/imu_cal_avg.sv]
// Moving-average lane: ring store, running sum, divide by window via reciprocal.
module imu_cal_avg #(
    parameter int unsigned WINDOW_LEN = imu_cal_pkg::IMU_WINDOW_LEN
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  imu_cal_pkg::imu_pipe_ctrl_t ctrl,
    input  imu_cal_pkg::sample_t        cal_in,
    output imu_cal_pkg::sample_t        avg
);
    import imu_cal_pkg::*;

    localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int unsigned RCP_W  = SUM_W + 1;
    localparam int unsigned PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SUM_W) / WINDOW_LEN);

    sample_t                 store_reg [WINDOW_LEN];
    logic [SLOT_W-1:0]       slot_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic                    neg_mag_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [SUM_W-1:0]        mag_rcp_reg;
    logic                    neg_rcp_reg;
    logic [SUM_W-1:0]        q0_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic                    neg_quo_reg;
    sample_t                 avg_reg;

    logic signed [SUM_W-1:0] sum_next;
    logic [SLOT_W-1:0]       slot_next;
    logic [SUM_W-1:0]        q0;
    logic [SUM_W-1:0]        quo;
    logic [SUM_W-1:0]        quo_signed;

    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(store_reg[slot_reg]) + SUM_W'(cal_in);
        slot_next = (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
        q0        = prod_reg[SUM_W +: SUM_W];
        // Reciprocal estimate is low by at most one.
        quo        = q0_reg + SUM_W'(rem_reg >= SUM_W'(WINDOW_LEN));
        quo_signed = neg_quo_reg ? SUM_W'(-quo) : quo;
    end

    // Window state: oldest sample leaves the sum as the new one enters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                store_reg[i] <= '0;
            end
            sum_reg  <= '0;
            slot_reg <= '0;
        end
        else if (ctrl.ld[ST_SUM])
        begin
            store_reg[slot_reg] <= cal_in;
            sum_reg             <= sum_next;
            slot_reg            <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[ST_MAG])
        begin
            neg_mag_reg <= sum_reg[SUM_W-1];
            mag_reg     <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        end
        if (ctrl.ld[ST_RECIP])
        begin
            prod_reg    <= PROD_W'(mag_reg) * PROD_W'(RECIP);
            mag_rcp_reg <= mag_reg;
            neg_rcp_reg <= neg_mag_reg;
        end
        if (ctrl.ld[ST_QUO])
        begin
            q0_reg      <= q0;
            rem_reg     <= mag_rcp_reg - SUM_W'(q0 * SUM_W'(WINDOW_LEN));
            neg_quo_reg <= neg_rcp_reg;
        end
        if (ctrl.ld[ST_AVG])
        begin
            avg_reg <= quo_signed[SAMPLE_W-1:0];
        end
    end

    assign avg = avg_reg;

endmodule

[rtl/core/imu_cal_merge.sv]
// Aligns calibrated lanes with the averages and holds the result register.
module imu_cal_merge (
    input  logic                        clk,
    input  imu_cal_pkg::imu_pipe_ctrl_t ctrl,
    input  imu_cal_pkg::sample_t        accel_cal [imu_cal_pkg::AXES],
    input  imu_cal_pkg::sample_t        gyro_cal [imu_cal_pkg::AXES],
    input  imu_cal_pkg::sample_t        compass_cal [imu_cal_pkg::AXES],
    input  imu_cal_pkg::sample_t        accel_avg [imu_cal_pkg::AXES],
    output imu_cal_pkg::imu_out_t       result
);
    import imu_cal_pkg::*;

    localparam int unsigned DLY = ST_AVG - ST_CAL;

    typedef struct packed {
        sample_t [AXES-1:0] accel;
        sample_t [AXES-1:0] gyro;
        sample_t [AXES-1:0] compass;
    } side_t;

    side_t    side_in;
    side_t    dly_reg [DLY];
    imu_out_t out_reg;
    imu_out_t out_next;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            side_in.accel[a]   = accel_cal[a];
            side_in.gyro[a]    = gyro_cal[a];
            side_in.compass[a] = compass_cal[a];
        end
    end

    // Calibrated values ride alongside the averaging stages.
    for (genvar s = 0; s < DLY; s++)
    begin : g_dly
        if (s == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (ctrl.ld[ST_CAL + 1])
                begin
                    dly_reg[0] <= side_in;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (ctrl.ld[ST_CAL + 1 + s])
                begin
                    dly_reg[s] <= dly_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        out_next.avg_accel_x = accel_avg[0];
        out_next.avg_accel_y = accel_avg[1];
        out_next.avg_accel_z = accel_avg[2];
        out_next.cal_accel_x = dly_reg[DLY-1].accel[0];
        out_next.cal_accel_y = dly_reg[DLY-1].accel[1];
        out_next.cal_accel_z = dly_reg[DLY-1].accel[2];
        out_next.gyro_x      = dly_reg[DLY-1].gyro[0];
        out_next.gyro_y      = dly_reg[DLY-1].gyro[1];
        out_next.gyro_z      = dly_reg[DLY-1].gyro[2];
        out_next.compass_x   = dly_reg[DLY-1].compass[0];
        out_next.compass_y   = dly_reg[DLY-1].compass[1];
        out_next.compass_z   = dly_reg[DLY-1].compass[2];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

[rtl/core/imu_cal_checker.sv]
// Port-level checks on the IMU core, bound to the top level.
module imu_cal_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input imu_cal_pkg::imu_out_t out_data
);
    import imu_cal_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_STAGES + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + CNT_W'(in_valid && in_ready)
                        - CNT_W'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_empty_no_throttle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input throttled with empty result register");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result presented with no sample in flight");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == CNT_W'(NUM_STAGES) && !out_ready |-> !in_ready)
        else $error("sample taken with all stages full");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(NUM_STAGES))
        else $error("more samples in flight than stages");

endmodule

bind imu_calibrate_and_average_core imu_cal_checker u_imu_cal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

[test/tb_imu_calibrate_and_average_core.sv]
// Self-checking testbench for the IMU calibration and accelerometer averaging core.
module tb_imu_calibrate_and_average_core;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_cal_pkg::*;

    // Signed copy of the window length so that averaging divides signed.
    localparam int WIN_LEN         = IMU_WINDOW_LEN;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int RANDOM_PHASES   = 9;
    localparam int RX_HOLD_CYCLES  = 60;   // long result back-pressure stretch
    localparam int WATCHDOG_LIMIT  = 1000; // cycles without any transfer
    localparam int MAX_PRINTED     = 40;
    localparam int OUT_FIELDS      = $bits(imu_out_t) / SAMPLE_W;

    // Handshake pacing: who idles how often.
    typedef enum int {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    imu_cal_stream_if #(.T(imu_in_t))  sample_ch ();
    imu_cal_stream_if #(.T(imu_out_t)) result_ch ();
    imu_cal_stream_if #(.T(imu_cfg_t)) cfg_ch ();

    imu_calibrate_and_average_core #(
        .WINDOW_LEN(IMU_WINDOW_LEN)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and the accelerometer ring
    // ------------------------------------------------------------------
    logic [REG_W-1:0] cal_regs [NUM_REGS];
    sample_t          accel_window [AXES][WIN_LEN];
    int               accel_window_sum [AXES];
    int               window_slot;

    imu_in_t  pending_samples [$];   // stimulus not yet offered
    imu_out_t expected_results [$];  // predictions awaiting their transfer

    pace_t pace          = PACE_RX_SLOW;
    int    samples_accepted = 0;
    int    stall_trigger = -1;
    bit    stall_done    = 1'b0;
    int    stall_left    = 0;
    int    quiet_cycles  = 0;
    int    mismatch_count = 0;
    logic  offer_next;
    imu_out_t want;
    sample_t  got_f;
    sample_t  want_f;

    string out_field_name [OUT_FIELDS] = '{
        "avg_accel_x", "avg_accel_y", "avg_accel_z",
        "cal_accel_x", "cal_accel_y", "cal_accel_z",
        "gyro_x", "gyro_y", "gyro_z",
        "compass_x", "compass_y", "compass_z"
    };

    function automatic sample_t clamp16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return sample_t'(v);
    endfunction

    function automatic sample_t reg_lane(int idx, int axis);
        return sample_t'(cal_regs[idx][SAMPLE_W*axis +: SAMPLE_W]);
    endfunction

    // Offset removal at 17 bits, full-width Q4.12 product, divide truncating
    // toward zero (SV signed division does that), then clamp.
    function automatic sample_t offset_and_scale(sample_t raw, sample_t off, sample_t gain);
        int diff;
        int prod;
        diff = int'(raw) - int'(off);
        prod = diff * int'(gain);
        return clamp16(prod / 4096);
    endfunction

    // Expected result for one accepted sample; advances the ring.
    function automatic imu_out_t calibrate_and_average(imu_in_t s);
        sample_t  acc_raw [AXES];
        sample_t  gyr_raw [AXES];
        sample_t  cps_raw [AXES];
        sample_t  acc [AXES];
        sample_t  gyr [AXES];
        sample_t  cps [AXES];
        sample_t  avg [AXES];
        imu_out_t r;
        acc_raw = '{s.accel_raw_x, s.accel_raw_y, s.accel_raw_z};
        gyr_raw = '{s.gyro_raw_x, s.gyro_raw_y, s.gyro_raw_z};
        cps_raw = '{s.compass_raw_x, s.compass_raw_y, s.compass_raw_z};
        for (int a = 0; a < AXES; a++)
        begin
            acc[a] = offset_and_scale(acc_raw[a], reg_lane(REG_ACCEL_OFFSETS, a),
                                      reg_lane(REG_ACCEL_GAINS, a));
            gyr[a] = clamp16(int'(gyr_raw[a]) - int'(reg_lane(REG_GYRO_OFFSETS, a)));
            cps[a] = offset_and_scale(cps_raw[a], reg_lane(REG_COMPASS_OFFSETS, a),
                                      reg_lane(REG_COMPASS_GAINS, a));
            accel_window_sum[a] -= int'(accel_window[a][window_slot]);
            accel_window[a][window_slot] = acc[a];
            accel_window_sum[a] += int'(acc[a]);
            avg[a] = clamp16(accel_window_sum[a] / WIN_LEN);
        end
        window_slot = (window_slot + 1 >= WIN_LEN) ? 0 : window_slot + 1;
        r.avg_accel_x = avg[0];
        r.avg_accel_y = avg[1];
        r.avg_accel_z = avg[2];
        r.cal_accel_x = acc[0];
        r.cal_accel_y = acc[1];
        r.cal_accel_z = acc[2];
        r.gyro_x      = gyr[0];
        r.gyro_y      = gyr[1];
        r.gyro_z      = gyr[2];
        r.compass_x   = cps[0];
        r.compass_y   = cps[1];
        r.compass_z   = cps[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic sample_t extreme_value();
        case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Mostly full-range, some small values so results are not all clipped.
    function automatic sample_t rand_axis();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: return sample_t'($urandom);
            7, 8: return sample_t'(int'($urandom_range(4000)) - 2000);
            default: return extreme_value();
        endcase
    endfunction

    function automatic imu_in_t rand_sample();
        imu_in_t s;
        s.accel_raw_x   = rand_axis();
        s.accel_raw_y   = rand_axis();
        s.accel_raw_z   = rand_axis();
        s.gyro_raw_x    = rand_axis();
        s.gyro_raw_y    = rand_axis();
        s.gyro_raw_z    = rand_axis();
        s.compass_raw_x = rand_axis();
        s.compass_raw_y = rand_axis();
        s.compass_raw_z = rand_axis();
        return s;
    endfunction

    function automatic sample_t rand_offset();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return sample_t'(int'($urandom_range(8192)) - 4096);
            6, 7, 8: return sample_t'($urandom);
            default: return extreme_value();
        endcase
    endfunction

    // Gains cluster around +1.0 and -1.0, with full-range and corner picks.
    function automatic sample_t rand_gain();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return sample_t'(int'($urandom_range(3072, 5120)));
            5, 6: return sample_t'(-int'($urandom_range(3072, 5120)));
            7, 8: return sample_t'($urandom);
            default: return extreme_value();
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_offsets();
        return {rand_offset(), rand_offset(), rand_offset()};
    endfunction

    function automatic logic [REG_W-1:0] rand_gains();
        return {rand_gain(), rand_gain(), rand_gain()};
    endfunction

    function automatic imu_in_t uniform_sample(sample_t v);
        return {9{v}};
    endfunction

    function automatic int sender_idle_pct();
        case (pace)
            PACE_RX_SLOW: return 36;
            PACE_TX_SLOW: return 66;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (pace)
            PACE_RX_SLOW: return 66;
            PACE_TX_SLOW: return 36;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // One register write transfer; predictor copy follows the transfer.
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_ch.data  <= imu_cfg_t'{index: idx, wdata: val};
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx < NUM_REGS)
            cal_regs[idx] = val;
    endtask

    // Sender pause: nothing queued, nothing offered, nothing outstanding.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid
               || expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Sample driver: offers queued items, predicts at each transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                expected_results.push_back(calibrate_and_average(sample_ch.data));
                samples_accepted <= samples_accepted + 1;
            end
            // valid is only touched when the current item is gone or none is held
            if (!sample_ch.valid || sample_ch.ready)
            begin
                offer_next = (pending_samples.size() != 0)
                             && (int'($urandom_range(99)) >= sender_idle_pct());
                if (offer_next)
                    sample_ch.data <= pending_samples.pop_front();
                sample_ch.valid <= offer_next;
            end
        end
    end

    // Long receiver hold-off, armed once by the stimulus; while it runs the
    // pipeline fills and the core must drop sample.ready.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
        end
        else if (!stall_done && samples_accepted == stall_trigger)
        begin
            stall_left <= RX_HOLD_CYCLES;
            stall_done <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: drives ready, checks each transfer field by field
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transfer with no sample outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    for (int k = 0; k < OUT_FIELDS; k++)
                    begin
                        got_f  = result_ch.data[$bits(imu_out_t)-1-SAMPLE_W*k -: SAMPLE_W];
                        want_f = want[$bits(imu_out_t)-1-SAMPLE_W*k -: SAMPLE_W];
                        if (got_f !== want_f)
                            report_mismatch($sformatf("%s got %0d expected %0d",
                                            out_field_name[k], got_f, want_f));
                    end
                end
            end
            result_ch.ready <= (stall_left == 0)
                               && (int'($urandom_range(99)) >= receiver_idle_pct());
        end
    end

    // Watchdog: ends the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("imu_calibrate_and_average_core regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;

        // Predictor starts from the reset image of the core.
        cal_regs[REG_ACCEL_OFFSETS]   = '0;
        cal_regs[REG_ACCEL_GAINS]     = GAIN_ONE_PACKED;
        cal_regs[REG_GYRO_OFFSETS]    = '0;
        cal_regs[REG_COMPASS_OFFSETS] = '0;
        cal_regs[REG_COMPASS_GAINS]   = GAIN_ONE_PACKED;
        for (int a = 0; a < AXES; a++)
        begin
            accel_window_sum[a] = 0;
            for (int i = 0; i < WIN_LEN; i++)
                accel_window[a][i] = '0;
        end
        window_slot = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset configuration: field extremes and bit patterns.
        // The first few averages cover the warm-up with zeros still in the ring.
        @(negedge clk);
        pending_samples.push_back(uniform_sample(16'sh0000));
        pending_samples.push_back(uniform_sample(16'sh7FFF));
        pending_samples.push_back(uniform_sample(16'sh8000));
        pending_samples.push_back(uniform_sample(16'shFFFF));
        pending_samples.push_back(uniform_sample(16'sh5555));
        pending_samples.push_back(uniform_sample(16'shAAAA));
        pending_samples.push_back(imu_in_t'{
            accel_raw_x: 16'sh7FFF, accel_raw_y: 16'sh8000, accel_raw_z: 16'sh0001,
            gyro_raw_x: 16'sh8000, gyro_raw_y: 16'sh7FFF, gyro_raw_z: 16'shFFFF,
            compass_raw_x: 16'sh0001, compass_raw_y: 16'sh8000, compass_raw_z: 16'sh7FFF});
        wait_drained();

        // Directed, corner configuration (lanes written z, y, x):
        // offsets at both rails push the 17-bit difference to its limits,
        // gains at +8, -8, +0.5 and -0.5 give saturation and remainders that
        // must truncate toward zero.
        write_reg(REG_ACCEL_OFFSETS,   {16'sh0001, 16'sh7FFF, 16'sh8000});
        write_reg(REG_ACCEL_GAINS,     {16'sh0800, 16'sh8000, 16'sh7FFF});
        write_reg(REG_GYRO_OFFSETS,    {16'sh0001, 16'sh7FFF, 16'sh8000});
        write_reg(REG_COMPASS_OFFSETS, {16'sh0000, 16'sh8000, 16'sh7FFF});
        write_reg(REG_COMPASS_GAINS,   {16'shF800, 16'sh7FFF, 16'sh8000});
        // Indexes past the register file must leave everything untouched.
        for (int k = 0; k < (1 << REG_IDX_W) - NUM_REGS; k++)
            write_reg(REG_IDX_W'(NUM_REGS + k), REG_W'({$urandom, $urandom}));
        @(negedge clk);
        pending_samples.push_back(uniform_sample(16'sh7FFF));
        pending_samples.push_back(uniform_sample(16'sh8000));
        pending_samples.push_back(uniform_sample(16'sh0000));
        pending_samples.push_back(uniform_sample(16'shFFFF));
        pending_samples.push_back(uniform_sample(16'sh0001));
        pending_samples.push_back(uniform_sample(16'sh0002));
        wait_drained();

        // Random phases: fresh configuration each time, pacing changes every
        // three phases (receiver slow, sender slow, then no idling at all).
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_reg(REG_ACCEL_OFFSETS,   rand_offsets());
            write_reg(REG_ACCEL_GAINS,     rand_gains());
            write_reg(REG_GYRO_OFFSETS,    rand_offsets());
            write_reg(REG_COMPASS_OFFSETS, rand_offsets());
            write_reg(REG_COMPASS_GAINS,   rand_gains());
            @(negedge clk);
            pace = pace_t'(p / 3);
            // Arm the long receiver hold-off in the first full-rate phase, so
            // the sender keeps offering while the results back up.
            if (pace == PACE_FULL && stall_trigger < 0)
                stall_trigger = samples_accepted + 20;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                pending_samples.push_back(rand_sample());
            wait_drained();
        end

        // Let anything stray come out before the verdict.
        repeat (NUM_STAGES + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("imu_calibrate_and_average_core regression: pass");
        else
            $display("imu_calibrate_and_average_core regression: fail");
        $finish;
    end

endmodule

[files.f]
rtl/core/imu_cal_pkg.sv
rtl/core/imu_cal_stream_if.sv
rtl/core/imu_cal_axis.sv
rtl/core/imu_cal_avg.sv
rtl/core/imu_cal_merge.sv
rtl/core/imu_calibrate_and_average_core.sv
rtl/core/imu_cal_checker.sv
test/tb_imu_calibrate_and_average_core.sv
